// ===== rtl/dmtp_pkg.sv =====
// ----------------------------------------------------------------------------
// dmtp_pkg
// Shared types and constants for the direct-mapped tag store with prefetch.
// ----------------------------------------------------------------------------
package dmtp_pkg;

	localparam int LINES_DEF        = 16;
	localparam int ADDR_BITS_DEF    = 16;
	localparam int MAX_PREFETCH_DEF = 16;
	localparam int COUNT_BITS_DEF   = 16;

	localparam int LOOP_DEFAULT = 2;

	localparam logic [1:0] HINT_LOAD = 2'd1;
	localparam logic [1:0] HINT_LOOP = 2'd2;

	localparam logic KIND_LOOKUP = 1'b0;
	localparam logic KIND_FILL   = 1'b1;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_IDX,
		S_EVAL,
		S_PF_RD,
		S_PF_WR,
		S_FIN_RD,
		S_FIN,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		UPD_LOOKUP,
		UPD_FILL,
		UPD_PREFETCH
	} upd_op_t;

	typedef struct packed {
		logic hit;
		logic installed;
		logic was_pf;
	} upd_stat_t;

endpackage

// ===== rtl/dmtp_ram.sv =====
// ----------------------------------------------------------------------------
// dmtp_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module dmtp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/dmtp_mod.sv =====
// ----------------------------------------------------------------------------
// dmtp_mod
// Line index from address: mask for a power-of-two line count, otherwise
// a restoring remainder, four address bits per cycle.
// ----------------------------------------------------------------------------
module dmtp_mod #(
	parameter int LINES = 16,
	parameter int ADDR_BITS = 16,
	localparam int LW = $clog2(LINES)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [ADDR_BITS-1:0] x,
	output logic                 done,
	output logic [LW-1:0]        r
);

	if ((LINES & (LINES - 1)) == 0) begin : g_pow2
		logic [ADDR_BITS-1:0] x_q;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				x_q <= '0;
			end else if (start) begin
				x_q <= x;
			end
		end

		assign done = 1'b1;
		assign r    = LW'(x_q);
	end else begin : g_rem
		localparam int STEP  = 4;
		localparam int STEPS = (ADDR_BITS + STEP - 1) / STEP;
		localparam int PW    = STEPS * STEP;
		localparam int TW    = LW + 1;
		localparam int CNW   = $clog2(STEPS + 1);

		logic [PW-1:0]  sh_q, sh_nx, ss;
		logic [LW-1:0]  r_q, r_nx, rr;
		logic [TW-1:0]  t;
		logic [CNW-1:0] cnt_q;
		logic           busy_q;

		always_comb begin
			rr = r_q;
			ss = sh_q;
			t  = '0;
			for (int j = 0; j < STEP; j++) begin
				t = {rr, ss[PW-1]};
				if (t >= TW'(LINES)) begin
					t = t - TW'(LINES);
				end
				rr = t[LW-1:0];
				ss = {ss[PW-2:0], 1'b0};
			end
			r_nx  = rr;
			sh_nx = ss;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				busy_q <= 1'b0;
				cnt_q  <= '0;
			end else if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNW'(STEPS);
			end else if (busy_q) begin
				busy_q <= (cnt_q != CNW'(1));
				cnt_q  <= cnt_q - CNW'(1);
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				sh_q <= PW'(x);
				r_q  <= '0;
			end else if (busy_q) begin
				sh_q <= sh_nx;
				r_q  <= r_nx;
			end
		end

		assign done = !busy_q;
		assign r    = r_q;
	end

endmodule

// ===== rtl/dmtp_upd.sv =====
// ----------------------------------------------------------------------------
// dmtp_upd
// Shared line update unit: tag compare and saturating counter bumps for
// lookup and fill, and prefetch install.
// ----------------------------------------------------------------------------
module dmtp_upd
	import dmtp_pkg::*;
#(
	parameter int ADDR_BITS = 16,
	parameter int COUNT_BITS = 16,
	localparam int EW = 2 + ADDR_BITS + 3 * COUNT_BITS
) (
	input  upd_op_t              op,
	input  logic                 en,
	input  logic [ADDR_BITS-1:0] addr,
	input  logic [EW-1:0]        entry_i,
	output logic [EW-1:0]        entry_o,
	output upd_stat_t            stat
);

	typedef struct packed {
		logic                  valid;
		logic                  pf;
		logic [ADDR_BITS-1:0]  tag;
		logic [COUNT_BITS-1:0] hits;
		logic [COUNT_BITS-1:0] misses;
		logic [COUNT_BITS-1:0] pfh;
	} entry_t;

	entry_t cur, nxt;
	logic   match;

	function automatic logic [COUNT_BITS-1:0] sat(input logic [COUNT_BITS-1:0] c);
		return (&c) ? c : c + COUNT_BITS'(1);
	endfunction

	assign cur   = entry_i;
	assign match = cur.valid && (cur.tag == addr);

	always_comb begin
		nxt  = cur;
		stat = '0;
		unique case (op)
			UPD_LOOKUP: begin
				if (en) begin
					stat.was_pf = cur.pf;
					stat.hit    = match;
					if (match) begin
						nxt.hits = sat(cur.hits);
						if (cur.pf) begin
							nxt.pfh = sat(cur.pfh);
						end
					end else begin
						nxt.misses = sat(cur.misses);
					end
				end
			end
			UPD_FILL: begin
				if (en) begin
					stat.was_pf = cur.pf;
					if (cur.valid && !match) begin
						nxt.misses = sat(cur.misses);
					end
					nxt.tag   = addr;
					nxt.valid = 1'b1;
				end
			end
			UPD_PREFETCH: begin
				if (!match) begin
					nxt.tag        = addr;
					nxt.valid      = 1'b1;
					nxt.pf         = 1'b1;
					nxt.pfh        = '0;
					stat.installed = 1'b1;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	assign entry_o = nxt;

endmodule

// ===== rtl/direct_mapped_tags_with_prefetch.sv =====
// ----------------------------------------------------------------------------
// direct_mapped_tags_with_prefetch
// Direct-mapped tag store with per-line counters and sequential prefetch.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                Payload
// in       request    in_valid / in_ready      kind, address, hint, loop_lines
// out      result     out_valid / out_ready    hit, line, pf_marked,
//                                              line_hits, line_misses,
//                                              line_prefetch_hits,
//                                              lines_prefetched
// cfg      write      cfg_wr_en                cfg_wr_data (enable)
//
// Steps per request without prefetch: accept, index, evaluate, deliver;
// a prefetch of n lines adds a read and a write per line through the one
// RAM port pair, then a re-read of the accessed line. With a line count that
// is not a power of two the index step takes a remainder, four bits at a time.
// Reset and a write of enable = 0 run a clearing sweep over all lines.
// The result waits in the output register; the next request is taken meanwhile.
// ----------------------------------------------------------------------------
module direct_mapped_tags_with_prefetch
	import dmtp_pkg::*;
#(
	parameter int LINES        = LINES_DEF,
	parameter int ADDR_BITS    = ADDR_BITS_DEF,
	parameter int MAX_PREFETCH = MAX_PREFETCH_DEF,
	parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [15:0] address,
	input  logic [1:0]  hint,
	input  logic [4:0]  loop_lines,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        hit,
	output logic [3:0]  line,
	output logic        pf_marked,
	output logic [15:0] line_hits,
	output logic [15:0] line_misses,
	output logic [15:0] line_prefetch_hits,
	output logic [4:0]  lines_prefetched,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data
);

	localparam int LW = $clog2(LINES);
	localparam int NW = $clog2(MAX_PREFETCH + 1);
	localparam int EW = 2 + ADDR_BITS + 3 * COUNT_BITS;

	typedef struct packed {
		logic                  valid;
		logic                  pf;
		logic [ADDR_BITS-1:0]  tag;
		logic [COUNT_BITS-1:0] hits;
		logic [COUNT_BITS-1:0] misses;
		logic [COUNT_BITS-1:0] pfh;
	} entry_t;

	state_t state_q, state_d;
	logic   enable_q;
	logic   out_valid_q;
	logic   out_load;
	logic   accept;

	logic                 kind_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [1:0]           hint_q;
	logic [NW-1:0]        n_q, n_d;
	logic [LW-1:0]        k_q;
	logic [ADDR_BITS-1:0] pa_q, pa_nxt, base_a;
	logic [LW-1:0]        pk_q, pk_nxt, base_k;
	logic [NW-1:0]        cnt_q;
	logic [NW-1:0]        fetched_q;
	logic [LW-1:0]        clr_q;

	logic                  res_hit_q;
	logic                  res_pf_q;
	logic [COUNT_BITS-1:0] res_hits_q;
	logic [COUNT_BITS-1:0] res_misses_q;
	logic [COUNT_BITS-1:0] res_pfh_q;

	logic        hit_q;
	logic [3:0]  line_q;
	logic        was_pf_q;
	logic [15:0] line_hits_q;
	logic [15:0] line_misses_q;
	logic [15:0] line_pfh_q;
	logic [4:0]  lines_pf_q;

	logic          ram_we;
	logic [LW-1:0] ram_waddr;
	logic [LW-1:0] ram_raddr;
	entry_t        ram_wdata;
	entry_t        ram_rdata;

	upd_op_t       upd_op;
	logic [ADDR_BITS-1:0] upd_addr;
	entry_t        upd_entry;
	upd_stat_t     upd_stat;
	logic          need_pf;

	logic          mod_done;
	logic [LW-1:0] mod_r;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE) && !cfg_wr_en;

	always_comb begin
		if (hint == HINT_LOAD) begin
			n_d = NW'(1);
		end else if (loop_lines == '0) begin
			n_d = NW'(LOOP_DEFAULT);
		end else if (32'(loop_lines) > MAX_PREFETCH) begin
			n_d = NW'(MAX_PREFETCH);
		end else begin
			n_d = NW'(loop_lines);
		end
	end

	dmtp_mod #(
		.LINES    (LINES),
		.ADDR_BITS(ADDR_BITS)
	) u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept),
		.x     (ADDR_BITS'(address)),
		.done  (mod_done),
		.r     (mod_r)
	);

	dmtp_ram #(
		.WIDTH(EW),
		.DEPTH(LINES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign upd_op   = (state_q == S_PF_WR) ? UPD_PREFETCH :
	                  (kind_q == KIND_FILL) ? UPD_FILL : UPD_LOOKUP;
	assign upd_addr = (state_q == S_PF_WR) ? pa_q : addr_q;

	dmtp_upd #(
		.ADDR_BITS (ADDR_BITS),
		.COUNT_BITS(COUNT_BITS)
	) u_upd (
		.op     (upd_op),
		.en     (enable_q),
		.addr   (upd_addr),
		.entry_i(ram_rdata),
		.entry_o(upd_entry),
		.stat   (upd_stat)
	);

	assign need_pf = enable_q && (kind_q == KIND_LOOKUP) && !upd_stat.hit &&
	                 ((hint_q == HINT_LOAD) || (hint_q == HINT_LOOP));

	// next prefetch address and its line, tracked incrementally
	assign base_a = (state_q == S_EVAL) ? addr_q : pa_q;
	assign base_k = (state_q == S_EVAL) ? k_q : pk_q;
	assign pa_nxt = base_a + ADDR_BITS'(1);
	assign pk_nxt = (pa_nxt == '0) ? '0 :
	                (base_k == LW'(LINES - 1)) ? '0 : base_k + LW'(1);

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = k_q;
		ram_wdata = upd_entry;
		ram_raddr = k_q;
		out_load  = 1'b0;
		unique case (state_q)
			S_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == LW'(LINES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					state_d = S_IDX;
				end
			end
			S_IDX: begin
				ram_raddr = mod_r;
				if (mod_done) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				ram_we  = enable_q;
				state_d = need_pf ? S_PF_RD : S_DONE;
			end
			S_PF_RD: begin
				ram_raddr = pk_q;
				state_d   = S_PF_WR;
			end
			S_PF_WR: begin
				ram_we    = 1'b1;
				ram_waddr = pk_q;
				state_d   = (cnt_q == n_q) ? S_FIN_RD : S_PF_RD;
			end
			S_FIN_RD: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (cfg_wr_en && !cfg_wr_data) begin
			state_d = S_CLR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			enable_q    <= 1'b1;
			out_valid_q <= 1'b0;
			clr_q       <= '0;
		end else begin
			state_q <= state_d;
			clr_q   <= (state_q == S_CLR) ? clr_q + LW'(1) : '0;
			if (cfg_wr_en) begin
				enable_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			addr_q <= ADDR_BITS'(address);
			hint_q <= hint;
			n_q    <= n_d;
		end
		if (state_q == S_IDX && mod_done) begin
			k_q <= mod_r;
		end
		if (state_q == S_EVAL) begin
			res_hit_q    <= upd_stat.hit;
			res_pf_q     <= upd_stat.was_pf;
			res_hits_q   <= upd_entry.hits;
			res_misses_q <= upd_entry.misses;
			res_pfh_q    <= upd_entry.pfh;
			fetched_q    <= '0;
			pa_q         <= pa_nxt;
			pk_q         <= pk_nxt;
			cnt_q        <= NW'(1);
		end
		if (state_q == S_PF_WR) begin
			if (upd_stat.installed) begin
				fetched_q <= fetched_q + NW'(1);
			end
			pa_q  <= pa_nxt;
			pk_q  <= pk_nxt;
			cnt_q <= cnt_q + NW'(1);
		end
		if (state_q == S_FIN) begin
			res_hits_q   <= ram_rdata.hits;
			res_misses_q <= ram_rdata.misses;
			res_pfh_q    <= ram_rdata.pfh;
		end
		if (out_load) begin
			hit_q         <= res_hit_q;
			line_q        <= 4'(k_q);
			was_pf_q      <= res_pf_q;
			line_hits_q   <= 16'(res_hits_q);
			line_misses_q <= 16'(res_misses_q);
			line_pfh_q    <= 16'(res_pfh_q);
			lines_pf_q    <= 5'(fetched_q);
		end
	end

	assign out_valid          = out_valid_q;
	assign hit                = hit_q;
	assign line               = line_q;
	assign pf_marked          = was_pf_q;
	assign line_hits          = line_hits_q;
	assign line_misses        = line_misses_q;
	assign line_prefetch_hits = line_pfh_q;
	assign lines_prefetched   = lines_pf_q;

`ifndef SYNTHESIS
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EVAL |-> 32'(k_q) < LINES)
		else $error("line index out of range");

	a_pk_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PF_WR |-> 32'(pk_q) < LINES)
		else $error("prefetch line index out of range");

	a_fetch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN_RD |-> fetched_q <= n_q)
		else $error("more lines installed than requested");

	a_no_pf_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL && !enable_q && !cfg_wr_en) |=> state_q == S_DONE)
		else $error("prefetch started while disabled");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result loaded outside deliver state");
`endif

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the direct-mapped tag store with prefetch. Requests
// are driven through valid/ready with random gaps and result back-pressure,
// a line-state predictor computes every result, and a scoreboard compares it
// field by field. Covers cold, hit, conflict and wrap cases, load and loop
// prefetch, enable toggling and repeated hits on a prefetched line.
// ----------------------------------------------------------------------------
module tb_top
	import dmtp_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] HINT_NONE = 2'd0;
	localparam logic [1:0] HINT_RSVD = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HIT_PAIRS      = 24;

	typedef struct packed {
		logic        hit;
		logic [3:0]  line;
		logic        was_pf;
		logic [15:0] hits;
		logic [15:0] misses;
		logic [15:0] pf_hits;
		logic [4:0]  fetched;
	} line_result_t;

	class cache_scoreboard;
		logic [15:0]  tag_of [16];
		bit           valid_of [16];
		bit           marked_of [16];
		logic [15:0]  hit_cnt [16];
		logic [15:0]  miss_cnt [16];
		logic [15:0]  pf_hit_cnt [16];
		bit           enabled;
		int           mismatches;
		line_result_t pending [$];

		function new();
			clear_lines();
			enabled = 1'b1;
			mismatches = 0;
		endfunction

		function void clear_lines();
			for (int i = 0; i < 16; i++) begin
				tag_of[i] = '0;
				valid_of[i] = 1'b0;
				marked_of[i] = 1'b0;
				hit_cnt[i] = '0;
				miss_cnt[i] = '0;
				pf_hit_cnt[i] = '0;
			end
		endfunction

		function void set_enable(bit v);
			enabled = v;
			if (!v)
				clear_lines();
		endfunction

		function logic [15:0] bumped(logic [15:0] c);
			return (c == 16'hFFFF) ? c : c + 16'd1;
		endfunction

		function logic [4:0] prefetch_run(logic [15:0] base, int unsigned count);
			logic [15:0] pa;
			logic [3:0]  l;
			logic [4:0]  done;
			done = '0;
			for (int unsigned i = 1; i <= count; i++) begin
				pa = base + 16'(i);
				l = pa[3:0];
				if (!(valid_of[l] && tag_of[l] == pa)) begin
					tag_of[l] = pa;
					valid_of[l] = 1'b1;
					marked_of[l] = 1'b1;
					pf_hit_cnt[l] = '0;
					done++;
				end
			end
			return done;
		endfunction

		function void note_request(logic k, logic [15:0] a, logic [1:0] h, logic [4:0] n);
			line_result_t r;
			logic [3:0]   ln;
			int unsigned  cnt;
			ln = a[3:0];
			r = '0;
			r.line = ln;
			if (enabled) begin
				r.was_pf = marked_of[ln];
				if (k == KIND_LOOKUP) begin
					r.hit = valid_of[ln] && (tag_of[ln] == a);
					if (r.hit) begin
						hit_cnt[ln] = bumped(hit_cnt[ln]);
						if (r.was_pf)
							pf_hit_cnt[ln] = bumped(pf_hit_cnt[ln]);
					end else begin
						miss_cnt[ln] = bumped(miss_cnt[ln]);
						if (h == HINT_LOAD) begin
							r.fetched = prefetch_run(a, 1);
						end else if (h == HINT_LOOP) begin
							cnt = (n == 0) ? LOOP_DEFAULT : n;
							if (cnt > MAX_PREFETCH_DEF)
								cnt = MAX_PREFETCH_DEF;
							r.fetched = prefetch_run(a, cnt);
						end
					end
				end else begin
					if (valid_of[ln] && tag_of[ln] != a)
						miss_cnt[ln] = bumped(miss_cnt[ln]);
					tag_of[ln] = a;
					valid_of[ln] = 1'b1;
				end
			end
			r.hits = hit_cnt[ln];
			r.misses = miss_cnt[ln];
			r.pf_hits = pf_hit_cnt[ln];
			pending.push_back(r);
		endfunction

		task report(string what, logic [15:0] got, logic [15:0] want);
			$display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
			mismatches++;
		endtask

		task check_result(line_result_t got);
			line_result_t want;
			if (pending.size() == 0) begin
				report("result with no request", 16'(got.line), '0);
			end else begin
				want = pending.pop_front();
				if (got.hit !== want.hit)
					report("hit", 16'(got.hit), 16'(want.hit));
				if (got.line !== want.line)
					report("line", 16'(got.line), 16'(want.line));
				if (got.was_pf !== want.was_pf)
					report("pf_marked", 16'(got.was_pf), 16'(want.was_pf));
				if (got.hits !== want.hits)
					report("line_hits", got.hits, want.hits);
				if (got.misses !== want.misses)
					report("line_misses", got.misses, want.misses);
				if (got.pf_hits !== want.pf_hits)
					report("line_prefetch_hits", got.pf_hits, want.pf_hits);
				if (got.fetched !== want.fetched)
					report("lines_prefetched", 16'(got.fetched), 16'(want.fetched));
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        kind;
	logic [15:0] address;
	logic [1:0]  hint;
	logic [4:0]  loop_lines;
	logic        out_valid;
	logic        out_ready;
	logic        hit;
	logic [3:0]  line;
	logic        pf_marked;
	logic [15:0] line_hits;
	logic [15:0] line_misses;
	logic [15:0] line_prefetch_hits;
	logic [4:0]  lines_prefetched;
	logic        cfg_wr_en;
	logic        cfg_wr_data;

	cache_scoreboard sb;
	bit idle_now;
	int quiet_cycles;

	direct_mapped_tags_with_prefetch dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.kind               (kind),
		.address            (address),
		.hint               (hint),
		.loop_lines         (loop_lines),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.hit                (hit),
		.line               (line),
		.pf_marked          (pf_marked),
		.line_hits          (line_hits),
		.line_misses        (line_misses),
		.line_prefetch_hits (line_prefetch_hits),
		.lines_prefetched   (lines_prefetched),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_wr_data        (cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en)
				sb.set_enable(cfg_wr_data);
			if (in_valid && in_ready)
				sb.note_request(kind, address, hint, loop_lines);
			if (out_valid && out_ready)
				sb.check_result({hit, line, pf_marked, line_hits, line_misses,
					line_prefetch_hits, lines_prefetched});
		end
	end

	// result back-pressure
	initial begin
		int hold;
		hold = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				out_ready <= 1'b0;
				hold--;
			end else begin
				out_ready <= 1'b1;
				if (idle_now && $urandom_range(0, 4) == 0)
					hold = $urandom_range(1, 16);
			end
		end
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("FAIL direct_mapped_tags_with_prefetch");
		$finish;
	end

	task send_request(logic k, logic [15:0] a, logic [1:0] h, logic [4:0] n);
		int gap;
		gap = (idle_now && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		address <= a;
		hint <= h;
		loop_lines <= n;
		do @(posedge clk); while (!in_ready);
	endtask

	task wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task write_enable(bit v);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function logic [1:0] pick_hint();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return HINT_NONE;
		else if (r < 6)
			return HINT_LOAD;
		else if (r < 9)
			return HINT_LOOP;
		return HINT_RSVD;
	endfunction

	task random_phase(int n_items, bit allow_idle);
		int sent, len;
		logic [15:0] base;
		logic [4:0]  n;
		sent = 0;
		while (sent < n_items) begin
			idle_now = allow_idle && ($urandom_range(0, 3) != 0);
			len = $urandom_range(1, 6);
			if ($urandom_range(0, 4) == 0) begin
				repeat (len)
					send_request(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
						2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)));
			end else begin
				len = $urandom_range(4, 16);
				if ($urandom_range(0, 3) == 0)
					base = 16'hFFF0 + 16'($urandom_range(0, 15));
				else
					base = 16'($urandom_range(0, 65535));
				for (int j = 0; j < len; j++) begin
					n = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
						: 5'($urandom_range(0, 6));
					if ($urandom_range(0, 5) == 0)
						send_request(KIND_FILL, base + 16'($urandom_range(0, len)),
							pick_hint(), n);
					else
						send_request(KIND_LOOKUP, base + 16'($urandom_range(0, len)),
							pick_hint(), n);
				end
			end
			sent += len;
		end
	endtask

	initial begin
		sb = new();
		idle_now = 1'b1;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_LOOKUP;
		address = '0;
		hint = HINT_NONE;
		loop_lines = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: cold miss, fill, hit, conflict, wrap, prefetch over own line
		send_request(KIND_LOOKUP, 16'h0000, HINT_NONE, 5'd0);
		send_request(KIND_FILL,   16'h0000, HINT_NONE, 5'd0);
		send_request(KIND_LOOKUP, 16'h0000, HINT_NONE, 5'd0);
		send_request(KIND_FILL,   16'h0010, HINT_LOOP, 5'd31);
		send_request(KIND_LOOKUP, 16'hFFFF, HINT_LOAD, 5'd0);
		send_request(KIND_LOOKUP, 16'h0000, HINT_NONE, 5'd0);
		send_request(KIND_LOOKUP, 16'h1234, HINT_LOOP, 5'd0);
		send_request(KIND_LOOKUP, 16'h2000, HINT_LOOP, 5'd16);
		send_request(KIND_LOOKUP, 16'h3000, HINT_LOOP, 5'd31);
		send_request(KIND_LOOKUP, 16'h3000, HINT_RSVD, 5'd5);
		send_request(KIND_LOOKUP, 16'h3001, HINT_LOAD, 5'd0);
		send_request(KIND_LOOKUP, 16'hFFF8, HINT_LOOP, 5'd17);
		send_request(KIND_LOOKUP, 16'h2005, HINT_LOOP, 5'd1);
		send_request(KIND_LOOKUP, 16'h2004, HINT_LOOP, 5'd3);
		send_request(KIND_FILL,   16'hABCD, HINT_LOOP, 5'd5);
		send_request(KIND_FILL,   16'hABCD, HINT_LOAD, 5'd0);
		send_request(KIND_LOOKUP, 16'hABCD, HINT_NONE, 5'd0);
		send_request(KIND_LOOKUP, 16'hFFFF, HINT_NONE, 5'd15);
		write_enable(1'b0);
		send_request(KIND_LOOKUP, 16'hABCD, HINT_LOOP, 5'd8);
		send_request(KIND_FILL,   16'h1111, HINT_NONE, 5'd0);
		write_enable(1'b1);
		send_request(KIND_LOOKUP, 16'h1111, HINT_LOAD, 5'd0);

		random_phase(420, 1'b1);
		write_enable(1'b0);
		random_phase(60, 1'b1);
		write_enable(1'b1);
		random_phase(420, 1'b1);
		write_enable(1'b1);

		// repeated hits and conflict misses on one prefetched line
		idle_now = 1'b0;
		write_enable(1'b0);
		write_enable(1'b1);
		send_request(KIND_LOOKUP, 16'h7776, HINT_LOAD, 5'd0);
		for (int i = 0; i < HIT_PAIRS; i++) begin
			send_request(KIND_LOOKUP, 16'h7777, HINT_NONE, 5'd0);
			send_request(KIND_LOOKUP, 16'h8887, HINT_NONE, 5'd0);
		end

		random_phase(400, 1'b0);

		wait_drained();
		repeat (50) @(posedge clk);
		if (sb.mismatches == 0)
			$display("PASS direct_mapped_tags_with_prefetch");
		else
			$display("FAIL direct_mapped_tags_with_prefetch");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/dmtp_pkg.sv
rtl/dmtp_ram.sv
rtl/dmtp_mod.sv
rtl/dmtp_upd.sv
rtl/direct_mapped_tags_with_prefetch.sv
tb/tb_top.sv
